[sv/chained_bucket_hash_map_assert.svh]
// Assertion macros used by the hash map RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef CHAINED_BUCKET_HASH_MAP_ASSERT_SVH
`define CHAINED_BUCKET_HASH_MAP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CBHM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CBHM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cbhm_pkg.sv]
// Shared types, codes and widths of the chained bucket hash map.
// No dependencies.
package cbhm_pkg;

    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int OP_W      = 2;
    localparam int ADMIT_W   = 2;
    localparam int ST_W      = 3;
    localparam int CNT_OUT_W = 14;
    localparam int BC_W      = 11;
    localparam logic [BC_W-1:0] BC_RESET = 11'd1021;
    localparam int SLOTS     = 3;
    localparam int SLOT_W    = KEY_W + VAL_W;
    localparam int SI_W      = 2;
    // remainder unit: bits of the key consumed per cycle
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = KEY_W / DIV_BITS;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // operation codes
    localparam logic [OP_W-1:0] OP_FIND_INS = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND_REM = 2'd3;

    // admit verdicts
    localparam logic [ADMIT_W-1:0] ADMIT_OK      = 2'd0;
    localparam logic [ADMIT_W-1:0] ADMIT_NOSPACE = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_EXIST    = 3'd0;
    localparam logic [ST_W-1:0] ST_NEW      = 3'd1;
    localparam logic [ST_W-1:0] ST_CONFLICT = 3'd2;
    localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd3;
    localparam logic [ST_W-1:0] ST_REFUSED  = 3'd4;
    localparam logic [ST_W-1:0] ST_FAIL     = 3'd5;

    typedef enum logic [2:0] {
        WR_NONE, WR_STORE, WR_CLEAR, WR_LINK, WR_NEW, WR_WIPE
    } t_wr_kind;

    typedef enum logic [1:0] {
        VS_ZERO, VS_SLOT, VS_REG
    } t_vsel;

    typedef struct packed {
        logic            load;
        logic            div_step;
        logic            rd;
        logic            rd_next;
        t_wr_kind        wr;
        logic            zero_set;
        logic            zero_clear;
        logic            res_load;
        logic [ST_W-1:0] res_st;
        t_vsel           res_vsel;
        logic            out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ADMIT_W-1:0] admit;
        logic               allow;
        logic               key_zero;
        logic               hit;
        logic               empty_any;
        logic               next_ok;
        logic               pool_full;
        logic               zero_present;
        logic               wipe_last;
        logic               out_busy;
    } t_dp_stat;

    // status for a new entry under the given admit verdict
    function automatic logic [ST_W-1:0] f_verdict(input logic [ADMIT_W-1:0] admit);
        logic [ST_W-1:0] st;
        if (admit == ADMIT_OK) begin
            st = ST_NEW;
        end else if (admit == ADMIT_NOSPACE) begin
            st = ST_NOSPACE;
        end else begin
            st = ST_REFUSED;
        end
        return st;
    endfunction

endpackage

[sv/cbhm_if.sv]
// Channel interfaces of the hash map: request, response and configuration.
// Depends on cbhm_pkg.
interface cbhm_req_if import cbhm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value_in;
    logic [ADMIT_W-1:0] put_admit;
    logic               remove_allowed;
    modport source (output valid, operation, key, value_in, put_admit, remove_allowed,
                    input ready);
    modport sink   (input valid, operation, key, value_in, put_admit, remove_allowed,
                    output ready);
endinterface

interface cbhm_rsp_if import cbhm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ST_W-1:0]      status;
    logic [VAL_W-1:0]     value_out;
    logic [CNT_OUT_W-1:0] entry_count;
    modport source (output valid, status, value_out, entry_count, input ready);
    modport sink   (input valid, status, value_out, entry_count, output ready);
endinterface

interface cbhm_cfg_if import cbhm_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [BC_W-1:0] bucket_count;
    modport source (output valid, bucket_count, input ready);
    modport sink   (input valid, bucket_count, output ready);
endinterface

[sv/cbhm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/cbhm_ctrl.sv]
// Sequencer of the hash map: clearing pass, remainder steps, chain walk, writes.
// Depends on cbhm_pkg and chained_bucket_hash_map_assert.svh.
`include "chained_bucket_hash_map_assert.svh"

module cbhm_ctrl import cbhm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_RDH  = 4'd4;
    localparam logic [3:0] S_RDN  = 4'd5;
    localparam logic [3:0] S_EV   = 4'd6;
    localparam logic [3:0] S_WST  = 4'd7;
    localparam logic [3:0] S_WCL  = 4'd8;
    localparam logic [3:0] S_WLK  = 4'd9;
    localparam logic [3:0] S_WNW  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]        r_state, n_state;
    logic [DIV_CW-1:0] r_dcnt, n_dcnt;
    t_dp_cmd           cmd;
    logic              is_rem;

    assign is_rem = (i_stat.op == OP_REMOVE) || (i_stat.op == OP_FIND_REM);

    // next state and datapath commands
    always_comb begin
        cmd        = '0;
        cmd.wr     = WR_NONE;
        cmd.res_vsel = VS_ZERO;
        n_state    = r_state;
        n_dcnt     = r_dcnt;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLR: begin
                cmd.wr = WR_WIPE;
                if (i_stat.wipe_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.key_zero) begin
                    // key zero lives in its own register
                    n_state      = S_DONE;
                    cmd.res_load = 1'b1;
                    if (is_rem) begin
                        if (!i_stat.zero_present) begin
                            cmd.res_st = ST_NEW;
                        end else begin
                            cmd.res_vsel = (i_stat.op == OP_FIND_REM) ? VS_REG : VS_ZERO;
                            if (!i_stat.allow) begin
                                cmd.res_st = ST_REFUSED;
                            end else begin
                                cmd.res_st     = ST_EXIST;
                                cmd.zero_clear = 1'b1;
                            end
                        end
                    end else if (i_stat.zero_present) begin
                        if (i_stat.op == OP_FIND_INS) begin
                            cmd.res_st   = ST_EXIST;
                            cmd.res_vsel = VS_REG;
                        end else begin
                            cmd.res_st = ST_CONFLICT;
                        end
                    end else if (i_stat.op == OP_FIND_INS &&
                                 f_verdict(i_stat.admit) != ST_NEW) begin
                        cmd.res_st = f_verdict(i_stat.admit);
                    end else begin
                        cmd.res_st   = ST_NEW;
                        cmd.zero_set = 1'b1;
                    end
                end else begin
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_dcnt       = r_dcnt + 1'b1;
                if (r_dcnt == DIV_CW'(DIV_STEPS - 1)) begin
                    n_state = S_RDH;
                end
            end
            S_RDH: begin
                cmd.rd  = 1'b1;
                n_state = S_EV;
            end
            S_RDN: begin
                cmd.rd      = 1'b1;
                cmd.rd_next = 1'b1;
                n_state     = S_EV;
            end
            S_EV: begin
                // decide on the bucket just read
                if (i_stat.op == OP_INSERT) begin
                    if (i_stat.empty_any) begin
                        cmd.res_load = 1'b1;
                        cmd.res_st   = ST_NEW;
                        n_state      = S_WST;
                    end else if (i_stat.next_ok) begin
                        n_state = S_RDN;
                    end else if (i_stat.pool_full) begin
                        cmd.res_load = 1'b1;
                        cmd.res_st   = ST_FAIL;
                        n_state      = S_DONE;
                    end else begin
                        cmd.res_load = 1'b1;
                        cmd.res_st   = ST_NEW;
                        n_state      = S_WLK;
                    end
                end else if (i_stat.hit) begin
                    cmd.res_load = 1'b1;
                    if (i_stat.op == OP_FIND_INS) begin
                        cmd.res_st   = ST_EXIST;
                        cmd.res_vsel = VS_SLOT;
                        n_state      = S_DONE;
                    end else begin
                        cmd.res_vsel = (i_stat.op == OP_FIND_REM) ? VS_SLOT : VS_ZERO;
                        if (!i_stat.allow) begin
                            cmd.res_st = ST_REFUSED;
                            n_state    = S_DONE;
                        end else begin
                            cmd.res_st = ST_EXIST;
                            n_state    = S_WCL;
                        end
                    end
                end else if (i_stat.next_ok) begin
                    n_state = S_RDN;
                end else begin
                    cmd.res_load = 1'b1;
                    n_state      = S_DONE;
                    if (is_rem) begin
                        cmd.res_st = ST_NEW;
                    end else if (!i_stat.empty_any && i_stat.pool_full) begin
                        cmd.res_st = ST_FAIL;
                    end else if (f_verdict(i_stat.admit) != ST_NEW) begin
                        cmd.res_st = f_verdict(i_stat.admit);
                    end else begin
                        cmd.res_st = ST_NEW;
                        n_state    = i_stat.empty_any ? S_WST : S_WLK;
                    end
                end
            end
            S_WST: begin
                cmd.wr  = WR_STORE;
                n_state = S_DONE;
            end
            S_WCL: begin
                cmd.wr  = WR_CLEAR;
                n_state = S_DONE;
            end
            S_WLK: begin
                cmd.wr  = WR_LINK;
                n_state = S_WNW;
            end
            S_WNW: begin
                cmd.wr  = WR_NEW;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_dcnt  <= n_dcnt;
        end
    end

    assign o_cmd = cmd;

    `CBHM_ASSERT_SAME(a_out_free, cmd.out_load, !i_stat.out_busy, "result loaded over a held one")
    `CBHM_ASSERT_SAME(a_ev_after_rd, r_state == S_EV,
        $past(r_state) == S_RDH || $past(r_state) == S_RDN, "bucket evaluated without a read")
    `CBHM_ASSERT_NEXT(a_accept_chk, r_state == S_IDLE && i_in_valid, r_state == S_CHK,
        "accepted request not checked")
    `CBHM_ASSERT_NEXT(a_grow_pair, r_state == S_WLK, r_state == S_WNW,
        "linked bucket not written")
endmodule

[sv/cbhm_dp.sv]
// Datapath of the hash map: request registers, remainder unit, bucket memory,
// key zero register, entry counter and result register. Depends on cbhm_pkg, cbhm_ram.
module cbhm_dp import cbhm_pkg::*; #(
    parameter int SUB_MAPS         = 4,
    parameter int MAX_BUCKETS      = 1024,
    parameter int OVERFLOW_BUCKETS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [VAL_W-1:0]     i_value_in,
    input  logic [ADMIT_W-1:0]   i_put_admit,
    input  logic                 i_remove_allowed,
    input  logic                 i_cfg_valid,
    input  logic [BC_W-1:0]      i_bucket_count,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [ST_W-1:0]      o_status,
    output logic [VAL_W-1:0]     o_value_out,
    output logic [CNT_OUT_W-1:0] o_entry_count,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat
);
    localparam int HOME_TOTAL = SUB_MAPS * MAX_BUCKETS;
    localparam int ALL_B      = HOME_TOTAL + OVERFLOW_BUCKETS;
    localparam int AW         = $clog2(ALL_B);
    localparam int NW         = $clog2(OVERFLOW_BUCKETS + 1);
    localparam int RW         = SLOTS * SLOT_W + NW;
    localparam int CW         = $clog2(ALL_B * SLOTS + 2);
    localparam int SMW        = (SUB_MAPS > 1) ? $clog2(SUB_MAPS) : 1;

    // request and working registers
    logic [BC_W-1:0]    r_bc;
    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;
    logic [ADMIT_W-1:0] r_admit;
    logic               r_allow;
    logic [KEY_W-1:0]   r_kshift;
    logic [BC_W-1:0]    r_home;
    logic [SMW-1:0]     r_sub;
    logic [AW-1:0]      r_cur;
    logic [NW-1:0]      r_pool;
    logic               r_zp;
    logic [VAL_W-1:0]   r_zv;
    logic [CW-1:0]      r_cnt;
    logic [AW-1:0]      r_wipe;
    logic [ST_W-1:0]    r_st;
    logic [VAL_W-1:0]   r_vo;
    logic               r_ovalid;
    logic [ST_W-1:0]    r_o_st;
    logic [VAL_W-1:0]   r_o_vo;
    logic [CNT_OUT_W-1:0] r_o_cnt;

    logic [BC_W-1:0]    n_div;
    logic [BC_W-1:0]    n_home;
    logic [SMW-1:0]     n_sub;
    logic [BC_W:0]      dt;
    logic [SMW:0]       du;
    logic [AW-1:0]      home_addr, next_addr, pool_addr, raddr, waddr;
    logic [RW-1:0]      rdata, wrow;
    logic [NW-1:0]      nxt;
    logic               hit, empty_any, we;
    logic [SI_W-1:0]    hit_idx, empty_idx;

    // divisor: bucket count held in 1..MAX_BUCKETS
    always_comb begin
        if (r_bc == '0) begin
            n_div = BC_W'(1);
        end else if (32'(r_bc) > MAX_BUCKETS) begin
            n_div = BC_W'(MAX_BUCKETS);
        end else begin
            n_div = r_bc;
        end
    end

    // remainder step: DIV_BITS key bits per cycle, most significant first
    always_comb begin
        n_home = r_home;
        n_sub  = r_sub;
        dt     = '0;
        du     = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            dt = {n_home, r_kshift[KEY_W-1-i]};
            if (dt >= {1'b0, n_div}) begin
                dt = dt - {1'b0, n_div};
            end
            n_home = dt[BC_W-1:0];
            du = {n_sub, r_kshift[KEY_W-1-i]};
            if (du >= (SMW+1)'(SUB_MAPS)) begin
                du = du - (SMW+1)'(SUB_MAPS);
            end
            n_sub = du[SMW-1:0];
        end
    end

    // bucket addresses
    assign home_addr = AW'(r_sub) * AW'(MAX_BUCKETS) + AW'(r_home);
    assign nxt       = rdata[SLOTS*SLOT_W +: NW];
    assign next_addr = AW'(HOME_TOTAL) + AW'(nxt) - AW'(1);
    assign pool_addr = AW'(HOME_TOTAL) + AW'(r_pool) - AW'(1);
    assign raddr     = i_cmd.rd_next ? next_addr : home_addr;

    // slot search in the bucket just read: first match, first empty
    always_comb begin
        hit       = 1'b0;
        hit_idx   = '0;
        empty_any = 1'b0;
        empty_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (rdata[s*SLOT_W +: KEY_W] == r_key) begin
                hit     = 1'b1;
                hit_idx = SI_W'(s);
            end
            if (rdata[s*SLOT_W +: KEY_W] == '0) begin
                empty_any = 1'b1;
                empty_idx = SI_W'(s);
            end
        end
    end

    // row to write back
    always_comb begin
        wrow  = rdata;
        waddr = r_cur;
        we    = 1'b1;
        unique case (i_cmd.wr)
            WR_STORE: begin
                wrow[empty_idx*SLOT_W +: SLOT_W] = {r_val, r_key};
            end
            WR_CLEAR: begin
                wrow[hit_idx*SLOT_W +: SLOT_W] = '0;
            end
            WR_LINK: begin
                wrow[SLOTS*SLOT_W +: NW] = r_pool + 1'b1;
            end
            WR_NEW: begin
                wrow          = '0;
                wrow[SLOT_W-1:0] = {r_val, r_key};
                waddr         = pool_addr;
            end
            WR_WIPE: begin
                wrow  = '0;
                waddr = r_wipe;
            end
            WR_NONE: begin
                we = 1'b0;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    cbhm_ram #(
        .WIDTH (RW),
        .DEPTH (ALL_B)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wrow),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_key    <= i_key;
            r_val    <= i_value_in;
            r_admit  <= i_put_admit;
            r_allow  <= i_remove_allowed;
            r_kshift <= i_key;
            r_home   <= '0;
            r_sub    <= '0;
        end else if (i_cmd.div_step) begin
            r_kshift <= r_kshift << DIV_BITS;
            r_home   <= n_home;
            r_sub    <= n_sub;
        end
        if (i_cmd.rd) begin
            r_cur <= raddr;
        end
        if (i_cmd.res_load) begin
            r_st <= i_cmd.res_st;
            unique case (i_cmd.res_vsel)
                VS_SLOT: r_vo <= rdata[hit_idx*SLOT_W + KEY_W +: VAL_W];
                VS_REG:  r_vo <= r_zv;
                default: r_vo <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_st  <= r_st;
            r_o_vo  <= r_vo;
            r_o_cnt <= CNT_OUT_W'(r_cnt);
        end
    end

    // control state: config, pool, key zero register, counter, wipe pointer, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc     <= BC_RESET;
            r_pool   <= '0;
            r_zp     <= 1'b0;
            r_zv     <= '0;
            r_cnt    <= '0;
            r_wipe   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bc <= i_bucket_count;
            end
            if (i_cmd.wr == WR_WIPE) begin
                r_wipe <= r_wipe + 1'b1;
            end
            if (i_cmd.wr == WR_LINK) begin
                r_pool <= r_pool + 1'b1;
            end
            if (i_cmd.zero_set) begin
                r_zp <= 1'b1;
                r_zv <= r_val;
            end else if (i_cmd.zero_clear) begin
                r_zp <= 1'b0;
                r_zv <= '0;
            end
            if (i_cmd.zero_set || i_cmd.wr == WR_STORE || i_cmd.wr == WR_NEW) begin
                r_cnt <= r_cnt + 1'b1;
            end else if ((i_cmd.zero_clear || i_cmd.wr == WR_CLEAR) && r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // status to the sequencer
    always_comb begin
        o_stat.op           = r_op;
        o_stat.admit        = r_admit;
        o_stat.allow        = r_allow;
        o_stat.key_zero     = (r_key == '0);
        o_stat.hit          = hit;
        o_stat.empty_any    = empty_any;
        o_stat.next_ok      = (nxt != '0) && (32'(nxt) <= OVERFLOW_BUCKETS);
        o_stat.pool_full    = (32'(r_pool) >= OVERFLOW_BUCKETS);
        o_stat.zero_present = r_zp;
        o_stat.wipe_last    = (r_wipe == AW'(ALL_B - 1));
        o_stat.out_busy     = r_ovalid && !i_out_ready;
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_o_st;
    assign o_value_out   = r_o_vo;
    assign o_entry_count = r_o_cnt;
endmodule

[sv/chained_bucket_hash_map.sv]
// Chained bucket hash map: 64-bit keys to 64-bit values in bucket memory.
// Requests enter on i_req (operation, key, value_in, put_admit,
// remove_allowed); each gives one response on o_rsp (status, value_out,
// entry_count). i_cfg writes bucket_count; take it only while idle.
// An item is accepted when valid and ready are both high.
// After reset the block runs a clearing pass over the whole bucket memory,
// one row per cycle (4352 rows at default parameters), and takes no
// request until it ends; configuration writes are taken throughout.
// Key zero is settled in the check state and goes straight to the final state.
// Other keys pass the check state, the remainder steps (4 key bits per cycle),
// a read and an evaluation of each bucket along the chain (memory read port),
// any writes and the final state. One request is in flight at a time;
// the next is accepted once the previous response is in the output register.
// If the receiver stalls, the response is held and a finished request waits
// in its last state until the output register frees up.
// Depends on cbhm_pkg, cbhm_if, cbhm_ctrl, cbhm_dp.
module chained_bucket_hash_map import cbhm_pkg::*; #(
    parameter int SUB_MAPS         = 4,
    parameter int MAX_BUCKETS      = 1024,
    parameter int OVERFLOW_BUCKETS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbhm_req_if.sink   i_req,
    cbhm_rsp_if.source o_rsp,
    cbhm_cfg_if.sink   i_cfg
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign i_cfg.ready = 1'b1;

    cbhm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cbhm_dp #(
        .SUB_MAPS         (SUB_MAPS),
        .MAX_BUCKETS      (MAX_BUCKETS),
        .OVERFLOW_BUCKETS (OVERFLOW_BUCKETS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_operation      (i_req.operation),
        .i_key            (i_req.key),
        .i_value_in       (i_req.value_in),
        .i_put_admit      (i_req.put_admit),
        .i_remove_allowed (i_req.remove_allowed),
        .i_cfg_valid      (i_cfg.valid),
        .i_bucket_count   (i_cfg.bucket_count),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_value_out      (o_rsp.value_out),
        .o_entry_count    (o_rsp.entry_count),
        .i_cmd            (cmd),
        .o_stat           (stat)
    );
endmodule
